/* rtl/sdcf_pkg.sv */
// Shared types, codes and the CRC-7 step for the SD SPI command framer.
`default_nettype none

package sdcf_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SCAN = 2'd1,
        PH_CAPT = 2'd2
    } t_phase;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_TX      = 2'd0;
    localparam t_kind KIND_RESP    = 2'd1;
    localparam t_kind KIND_TIMEOUT = 2'd2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_RX    = 1'b1;

    localparam logic [1:0] CMD_HDR       = 2'b01;  // start bit 0, transmission bit 1
    localparam logic [6:0] CRC7_POLY     = 7'h09;  // x^7 + x^3 + 1
    localparam logic [7:0] LIMIT_RESET   = 8'd10;
    localparam logic [2:0] TX_LAST_IDX   = 3'd5;   // CRC byte is the sixth
    localparam logic [2:0] LEN_RESET     = 3'd1;

    // One byte through CRC-7, MSB first.
    function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] b);
        logic [6:0] c;
        logic       fb;
        c = crc_in;
        for (int k = 7; k >= 0; k--) begin
            fb = c[6] ^ b[k];
            c  = {c[5:0], 1'b0};
            if (fb) begin
                c = c ^ CRC7_POLY;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/sdcf_in_if.sv */
// Command/receive channel: valid/ready handshake with the input item fields.
`default_nettype none

interface sdcf_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [5:0]  command_index;
    logic [31:0] argument;
    logic [2:0]  response_length;
    logic [7:0]  rx_byte;

    modport source (output valid, output operation, output command_index,
                    output argument, output response_length, output rx_byte,
                    input ready);
    modport sink   (input valid, input operation, input command_index,
                    input argument, input response_length, input rx_byte,
                    output ready);
endinterface

`default_nettype wire

/* rtl/sdcf_out_if.sv */
// Result channel: valid/ready handshake with the result item fields.
`default_nettype none

interface sdcf_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output kind, output data_byte, output last,
                    input ready);
    modport sink   (input valid, input kind, input data_byte, input last,
                    output ready);
endinterface

`default_nettype wire

/* rtl/sd_spi_command_framer_unit.sv */
// Top level: SD SPI-mode command framer with CRC-7 and response capture.
// A received byte that yields a result has it in the output register in the cycle after acceptance.
// Throughput: one received byte per cycle, limited by the single output register and held off while a frame goes out.
// A start taken while idle blocks input while the frame emitter drives the six transmit
// bytes, one per cycle while the result register is free, the first after the emitter goes active.
// Reset (synchronous, active low) returns to idle, limit 10, output empty.
`default_nettype none

module sd_spi_command_framer_unit
    import sdcf_pkg::*;
#(
    parameter int MAX_RESPONSE_BYTES = 5
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    sdcf_in_if.sink    i_cmd,
    sdcf_out_if.source o_res,
    input  wire        i_cfg_we,
    input  wire [7:0]  i_cfg_data
);

    // response_length is a 3-bit field, so the clamp never needs more than 7
    localparam int         LEN_CLAMP = (MAX_RESPONSE_BYTES > 7) ? 7 : MAX_RESPONSE_BYTES;
    localparam logic [2:0] LEN_MAX   = 3'(LEN_CLAMP);

    // configuration and response tracking
    logic [7:0]  r_limit;
    t_phase      r_phase,     n_phase;
    logic [7:0]  r_attempts,  n_attempts;
    logic [2:0]  r_bytes_left, n_bytes_left;
    logic [2:0]  r_exp_len,   n_exp_len;

    // frame emitter: 40-bit shift of header+argument, running CRC, byte count
    logic        r_tx_active, n_tx_active;
    logic [2:0]  r_tx_cnt,    n_tx_cnt;
    logic [39:0] r_tx_sh,     n_tx_sh;
    logic [6:0]  r_crc,       n_crc;

    // result register
    logic        r_out_valid, n_out_valid;
    t_kind       r_out_kind,  n_out_kind;
    logic [7:0]  r_out_data,  n_out_data;
    logic        r_out_last,  n_out_last;

    logic        out_free;
    logic        in_acc;
    logic [7:0]  tx_byte;
    logic [7:0]  lim;
    logic [7:0]  att_inc;
    logic [2:0]  len_in;
    logic [2:0]  bl_dec;

    // The result register frees up when empty or when its transaction completes.
    assign out_free    = !r_out_valid || o_res.ready;
    // Input waits while a frame is still going out.
    assign i_cmd.ready = !r_tx_active && out_free;
    assign in_acc      = i_cmd.valid && i_cmd.ready;

    // Sixth frame byte is the CRC with the end bit; earlier ones come off the shifter.
    assign tx_byte = (r_tx_cnt == TX_LAST_IDX) ? {r_crc, 1'b1} : r_tx_sh[39:32];

    // A limit of zero acts as one.
    assign lim     = (r_limit == 8'd0) ? 8'd1 : r_limit;
    assign att_inc = r_attempts + 8'd1;

    always_comb begin
        if (i_cmd.response_length == 3'd0) begin
            len_in = 3'd1;
        end else if (i_cmd.response_length > LEN_MAX) begin
            len_in = LEN_MAX;
        end else begin
            len_in = i_cmd.response_length;
        end
    end

    assign bl_dec = (r_bytes_left != 3'd0) ? (r_bytes_left - 3'd1) : r_bytes_left;

    always_comb begin
        n_phase      = r_phase;
        n_attempts   = r_attempts;
        n_bytes_left = r_bytes_left;
        n_exp_len    = r_exp_len;
        n_tx_active  = r_tx_active;
        n_tx_cnt     = r_tx_cnt;
        n_tx_sh      = r_tx_sh;
        n_crc        = r_crc;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_kind   = r_out_kind;
        n_out_data   = r_out_data;
        n_out_last   = r_out_last;

        if (r_tx_active && out_free) begin
            n_out_valid = 1'b1;
            n_out_kind  = KIND_TX;
            n_out_data  = tx_byte;
            n_out_last  = (r_tx_cnt == TX_LAST_IDX);
            n_tx_sh     = {r_tx_sh[31:0], 8'd0};
            n_crc       = crc7_byte(r_crc, tx_byte);
            n_tx_cnt    = r_tx_cnt + 3'd1;
            if (r_tx_cnt == TX_LAST_IDX) begin
                n_tx_active = 1'b0;
            end
        end

        if (in_acc) begin
            if (i_cmd.operation == OP_START) begin
                // start while a response is pending is dropped
                if (r_phase != PH_SCAN && r_phase != PH_CAPT) begin
                    n_tx_active  = 1'b1;
                    n_tx_cnt     = 3'd0;
                    n_tx_sh      = {CMD_HDR, i_cmd.command_index, i_cmd.argument};
                    n_crc        = 7'd0;
                    n_exp_len    = len_in;
                    n_attempts   = 8'd0;
                    n_bytes_left = 3'd0;
                    n_phase      = PH_SCAN;
                end
            end else begin
                unique case (r_phase)
                    PH_SCAN: begin
                        if (i_cmd.rx_byte[7]) begin
                            n_attempts = att_inc;
                            if (att_inc >= lim) begin
                                n_out_valid = 1'b1;
                                n_out_kind  = KIND_TIMEOUT;
                                n_out_data  = 8'd0;
                                n_out_last  = 1'b1;
                                n_phase     = PH_IDLE;
                            end
                        end else begin
                            n_out_valid = 1'b1;
                            n_out_kind  = KIND_RESP;
                            n_out_data  = i_cmd.rx_byte;
                            if (r_exp_len <= 3'd1) begin
                                n_out_last = 1'b1;
                                n_phase    = PH_IDLE;
                            end else begin
                                n_out_last   = 1'b0;
                                n_bytes_left = r_exp_len - 3'd1;
                                n_phase      = PH_CAPT;
                            end
                        end
                    end
                    PH_CAPT: begin
                        n_bytes_left = bl_dec;
                        n_out_valid  = 1'b1;
                        n_out_kind   = KIND_RESP;
                        n_out_data   = i_cmd.rx_byte;
                        n_out_last   = (bl_dec == 3'd0);
                        if (bl_dec == 3'd0) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        // byte while idle: dropped
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit      <= LIMIT_RESET;
            r_phase      <= PH_IDLE;
            r_attempts   <= 8'd0;
            r_bytes_left <= 3'd0;
            r_exp_len    <= LEN_RESET;
            r_tx_active  <= 1'b0;
            r_tx_cnt     <= 3'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            r_phase      <= n_phase;
            r_attempts   <= n_attempts;
            r_bytes_left <= n_bytes_left;
            r_exp_len    <= n_exp_len;
            r_tx_active  <= n_tx_active;
            r_tx_cnt     <= n_tx_cnt;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_tx_sh    <= n_tx_sh;
        r_crc      <= n_crc;
        r_out_kind <= n_out_kind;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.kind      = r_out_kind;
    assign o_res.data_byte = r_out_data;
    assign o_res.last      = r_out_last;

endmodule

`default_nettype wire

/* rtl/sdcf_checker.sv */
// Port-level checks for the SD SPI command framer, bound to the top level.
`default_nettype none

module sdcf_checker
    import sdcf_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_ready,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [1:0] i_out_kind,
    input wire [7:0] i_out_data,
    input wire       i_out_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data)
            && $stable(i_out_kind) && $stable(i_out_last))
        else $error("result changed while stalled");

    // timeout carries zero data and closes the response
    a_timeout_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_TIMEOUT |-> i_out_data == 8'd0 && i_out_last)
        else $error("malformed timeout result");

    // last frame byte carries the end bit
    a_crc_end_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_TX && i_out_last |-> i_out_data[0])
        else $error("CRC byte without end bit");

    // input is held off while a frame is mid-flight
    a_frame_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_TX && !i_out_last |-> !i_in_ready)
        else $error("input accepted during frame output");

endmodule

bind sd_spi_command_framer_unit sdcf_checker u_sdcf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_kind  (o_res.kind),
    .i_out_data  (o_res.data_byte),
    .i_out_last  (o_res.last)
);

`default_nettype wire
